>>> hw/rtl/cat_pkg.sv
package cat_pkg;

	typedef enum logic [1:0] {
		OP_SCAN   = 2'd0,
		OP_GRANT  = 2'd1,
		OP_DENY   = 2'd2,
		OP_DELETE = 2'd3
	} cat_op_t;

	typedef enum logic [3:0] {
		ST_SCAN_GRANTED = 4'd0,
		ST_SCAN_DENIED  = 4'd1,
		ST_NOT_FOUND    = 4'd2,
		ST_SET_GRANTED  = 4'd3,
		ST_SET_DENIED   = 4'd4,
		ST_DELETED      = 4'd5,
		ST_ADDED        = 4'd6,
		ST_INVALID      = 4'd7,
		ST_FULL         = 4'd8
	} cat_status_t;

	typedef enum logic [1:0] {
		WR_NONE = 2'd0,
		WR_SET  = 2'd1,
		WR_MOVE = 2'd2,
		WR_ADD  = 2'd3
	} cat_wr_t;

	// controller to datapath
	typedef struct packed {
		logic        load;
		logic        search;
		logic        rd_last;
		cat_wr_t     wr_sel;
		logic        acc_val;
		logic        emit;
		cat_status_t code;
	} cat_cmd_t;

	// datapath to controller
	typedef struct packed {
		cat_op_t op;
		logic    card_zero;
		logic    hit;
		logic    hit_acc;
		logic    miss;
		logic    full;
	} cat_sts_t;

endpackage

>>> hw/rtl/cat_ctrl.sv
module cat_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cat_pkg::cat_sts_t sts,
	output cat_pkg::cat_cmd_t cmd,
	output logic              busy
);
	import cat_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SEARCH = 3'b010,
		S_DEL_WR = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd.load    = 1'b0;
		cmd.search  = 1'b0;
		cmd.rd_last = 1'b0;
		cmd.wr_sel  = WR_NONE;
		cmd.acc_val = 1'b0;
		cmd.emit    = 1'b0;
		cmd.code    = ST_NOT_FOUND;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (sts.op != OP_SCAN && sts.card_zero) begin
					cmd.emit = 1'b1;
					cmd.code = ST_INVALID;
					state_d  = S_IDLE;
				end else if (sts.hit) begin
					case (sts.op)
						OP_SCAN: begin
							cmd.emit = 1'b1;
							cmd.code = sts.hit_acc ? ST_SCAN_GRANTED : ST_SCAN_DENIED;
							state_d  = S_IDLE;
						end
						OP_GRANT: begin
							cmd.wr_sel  = WR_SET;
							cmd.acc_val = 1'b1;
							cmd.emit    = 1'b1;
							cmd.code    = ST_SET_GRANTED;
							state_d     = S_IDLE;
						end
						OP_DENY: begin
							cmd.wr_sel = WR_SET;
							cmd.emit   = 1'b1;
							cmd.code   = ST_SET_DENIED;
							state_d    = S_IDLE;
						end
						default: begin
							// fetch the last entry to fill the freed slot
							cmd.rd_last = 1'b1;
							state_d     = S_DEL_WR;
						end
					endcase
				end else if (sts.miss) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
					if (sts.op == OP_SCAN) begin
						cmd.code = ST_NOT_FOUND;
					end else if (sts.full) begin
						cmd.code = ST_FULL;
					end else begin
						cmd.wr_sel = WR_ADD;
						cmd.code   = ST_ADDED;
					end
				end else begin
					cmd.search = 1'b1;
				end
			end
			S_DEL_WR: begin
				cmd.wr_sel = WR_MOVE;
				cmd.emit   = 1'b1;
				cmd.code   = ST_DELETED;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

>>> hw/rtl/cat_dp.sv
module cat_dp #(
	parameter int TABLE_DEPTH = 64,
	parameter int CARD_BITS   = 31,
	localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           opcode,
	input  logic [CARD_BITS-1:0] card_number,
	input  cat_pkg::cat_cmd_t    cmd,
	output cat_pkg::cat_sts_t    sts,
	output logic                 done,
	output logic [3:0]           status,
	output logic                 lamp_green,
	output logic [CNT_W-1:0]     entries_used
);
	import cat_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic [1:0]           op_q;
	logic [CARD_BITS-1:0] card_q;
	logic [CNT_W-1:0]     cnt_q, cnt_d, idx_q, last;
	logic [IDX_W-1:0]     rd_addr, wr_addr, cmp_idx_q;
	logic                 wr_en, wr_acc, more;
	logic [CARD_BITS-1:0] wr_card;

	logic [CARD_BITS-1:0] mem_card [TABLE_DEPTH];
	logic                 mem_acc  [TABLE_DEPTH];
	logic [CARD_BITS-1:0] rd_card_q;
	logic                 rd_acc_q, rd_vld_q;

	logic                 done_q, lamp_q;
	logic [3:0]           status_q;
	logic [CNT_W-1:0]     used_q;

	assign more = (idx_q < cnt_q);
	assign last = cnt_q - CNT_W'(1);

	always_comb begin
		rd_addr = cmd.rd_last ? last[IDX_W-1:0] : idx_q[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = cmp_idx_q;
		wr_card = card_q;
		wr_acc  = cmd.acc_val;
		cnt_d   = cnt_q;
		case (cmd.wr_sel)
			WR_SET: begin
				wr_en = 1'b1;
			end
			WR_MOVE: begin
				wr_en   = 1'b1;
				wr_card = rd_card_q;
				wr_acc  = rd_acc_q;
				cnt_d   = last;
			end
			WR_ADD: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q[IDX_W-1:0];
				wr_acc  = 1'b1;
				cnt_d   = cnt_q + CNT_W'(1);
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_card[wr_addr] <= wr_card;
			mem_acc[wr_addr]  <= wr_acc;
		end
		rd_card_q <= mem_card[rd_addr];
		rd_acc_q  <= mem_acc[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			card_q <= card_number;
		end
		if (cmd.search) begin
			cmp_idx_q <= idx_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			idx_q    <= '0;
			rd_vld_q <= 1'b0;
			done_q   <= 1'b0;
			status_q <= '0;
			lamp_q   <= 1'b0;
			used_q   <= '0;
		end else begin
			cnt_q    <= cnt_d;
			rd_vld_q <= cmd.search && more;
			done_q   <= cmd.emit;
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.search && more) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (cmd.emit) begin
				status_q <= cmd.code;
				lamp_q   <= (cmd.code == ST_SCAN_GRANTED);
				used_q   <= cnt_d;
			end
		end
	end

	always_comb begin
		sts.op        = cat_op_t'(op_q);
		sts.card_zero = (card_q == '0);
		sts.hit       = rd_vld_q && (rd_card_q == card_q);
		sts.hit_acc   = rd_acc_q;
		// nothing in flight and nothing left to read
		sts.miss      = !rd_vld_q && !more;
		sts.full      = (cnt_q == CNT_W'(TABLE_DEPTH));
	end

	assign done         = done_q;
	assign status       = status_q;
	assign lamp_green   = lamp_q;
	assign entries_used = used_q;

endmodule

>>> hw/rtl/card_access_table_unit.sv
// Card access table: one request (opcode, card_number) is taken when start is high and busy
// is low, and exactly one result comes back on status, lamp_green and entries_used, shown for
// a single cycle with done high; the receiver cannot stall it, so it must take every result
// as it appears. The table is searched one entry per cycle through a memory with one read
// port, one write port and registered read. A hit answers once its card's entry has been
// read and compared, a miss once every stored entry has been read, a delete takes an extra
// step after its hit to move the last entry into the freed slot, and an invalid (zero) card
// on grant, deny or delete is answered without a search. busy falls in the cycle done is
// shown, so the next request may be accepted at the edge that takes the result.
// Memory contents need no clearing after reset.
module card_access_table_unit #(
	parameter int TABLE_DEPTH = 64,
	parameter int CARD_BITS   = 31,
	localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           opcode,
	input  logic [CARD_BITS-1:0] card_number,
	output logic                 done,
	output logic [3:0]           status,
	output logic                 lamp_green,
	output logic [CNT_W-1:0]     entries_used
);
	import cat_pkg::*;

	cat_cmd_t cmd;
	cat_sts_t sts;

	cat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	cat_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.CARD_BITS   (CARD_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.opcode       (opcode),
		.card_number  (card_number),
		.cmd          (cmd),
		.sts          (sts),
		.done         (done),
		.status       (status),
		.lamp_green   (lamp_green),
		.entries_used (entries_used)
	);

endmodule

>>> hw/rtl/cat_chk.sv
module cat_chk #(
	parameter int TABLE_DEPTH = 64,
	parameter int CARD_BITS   = 31,
	localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic [1:0]           opcode,
	input logic [CARD_BITS-1:0] card_number,
	input logic                 done,
	input logic [3:0]           status,
	input logic                 lamp_green,
	input logic [CNT_W-1:0]     entries_used
);
	import cat_pkg::*;

	// lamp only on a granted scan
	a_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (lamp_green == (status == ST_SCAN_GRANTED)))
		else $error("lamp_green does not match status");

	// the count only moves together with a result
	a_used_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(entries_used) |-> done)
		else $error("entries_used changed without a result");

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (entries_used <= CNT_W'(TABLE_DEPTH)))
		else $error("entries_used beyond table depth");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a request in progress");

endmodule

bind card_access_table_unit cat_chk #(
	.TABLE_DEPTH (TABLE_DEPTH),
	.CARD_BITS   (CARD_BITS)
) u_cat_chk (.*);
